// ----- rtl/isl_pkg.sv -----
// Package for the indexed sequence list: sizes, request and status codes,
// sequencer states and the structs between sequencer and top level.
// No dependencies.
package isl_pkg;

  // Store size and derived widths
  localparam int DEPTH    = 64;
  localparam int AddrW    = $clog2(DEPTH);
  localparam int CntW     = $clog2(DEPTH + 1);
  localparam int PosW     = 7;
  localparam int CountW   = 7;
  localparam int ValW     = 32;
  localparam int CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_READ   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SH_UP,
    S_FILL,
    S_SH_DN,
    S_RD_WAIT
  } seq_state_e;

  // RAM access issued by the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ValW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // Completion info handed to the top level
  typedef struct packed {
    logic    fin;
    status_e status;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_take;
  } res_t;

endpackage

// ----- rtl/indexed_sequence_list.sv -----
// Indexed sequence list: an ordered store of up to DEPTH signed 32-bit values
// with append, positional insert, positional delete and positional read.
// Each accepted request (start high while busy is low) returns one result on
// read_value_o, status_o and count_o, marked by done_o for exactly one cycle;
// the receiver cannot stall it, so it must take the result in that cycle.
// Append, insert at the end of the list, any refused request and delete of
// the last entry finish in S_EVAL; read waits in S_RD_WAIT for the registered
// RAM data; an insert that moves entries walks them up in S_SH_UP and then
// writes the new value in S_FILL, and a delete walks them down in S_SH_DN. The
// pace is set by the single write port of the entry RAM: insert and delete
// move one entry per cycle. busy is low again in the cycle that shows
// done_o, so the next request may be accepted then. Uses isl_pkg, isl_seq and
// isl_ram.
module indexed_sequence_list import isl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action_i,
  input  logic [PosW-1:0]   position_i,
  input  logic [ValW-1:0]   value_i,
  output logic              done_o,
  output logic [ValW-1:0]   read_value_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] count_o
);

  mem_req_t        mem;
  res_t            res;
  logic [ValW-1:0] rdata;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  status_e         status_q;
  logic [ValW-1:0] rd_val_q;

  isl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .action_i   (action_i),
    .position_i (position_i),
    .value_i    (value_i),
    .cnt_i      (cnt_q),
    .rdata_i    (rdata),
    .mem_o      (mem),
    .res_o      (res)
  );

  isl_ram #(
    .Width (ValW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .raddr_i (mem.raddr),
    .rdata_o (rdata)
  );

  // entry count update
  always_comb begin
    cnt_d = cnt_q;
    if (res.cnt_inc)      cnt_d = cnt_q + CntW'(1);
    else if (res.cnt_dec) cnt_d = cnt_q - CntW'(1);
  end

  // control state: count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= res.fin;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res.fin) begin
      status_q <= res.status;
      rd_val_q <= res.rd_take ? rdata : '0;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = rd_val_q;
  assign status_o     = status_q;
  assign count_o      = CountW'(cnt_q);

  // checks
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while request still in progress");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(cnt_q) <= CmpW'(DEPTH))
    else $error("entry count above store depth");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted request did not raise busy");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q == ST_FULL) |-> (CmpW'(cnt_q) == CmpW'(DEPTH)))
    else $error("full status with room left in store");

endmodule

// ----- rtl/isl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/isl_seq.sv -----
// Request sequencer: latches a request, checks it against the count and
// walks the RAM one entry per cycle for insert and delete. Uses isl_pkg.
module isl_seq import isl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [PosW-1:0]  position_i,
  input  logic [ValW-1:0]  value_i,
  input  logic [CntW-1:0]  cnt_i,
  input  logic [ValW-1:0]  rdata_i,
  output mem_req_t         mem_o,
  output res_t             res_o
);

  seq_state_e       state_q, state_d;
  act_e             act_q;
  logic [PosW-1:0]  pos_q;
  logic [ValW-1:0]  val_q;
  logic [AddrW-1:0] ptr_q, ptr_d;

  logic [CmpW-1:0] pos_x, cnt_x, ptr_x;
  logic            full, pos_gt, pos_ge, pos_at_end, del_shift, up_more, dn_more;

  assign busy = (state_q != S_IDLE);

  // shared compare unit
  assign pos_x      = CmpW'(pos_q);
  assign cnt_x      = CmpW'(cnt_i);
  assign ptr_x      = CmpW'(ptr_q);
  assign full       = (cnt_x >= CmpW'(DEPTH));
  assign pos_gt     = (pos_x > cnt_x);
  assign pos_ge     = (pos_x >= cnt_x);
  assign pos_at_end = (pos_x == cnt_x);
  assign del_shift  = ((pos_x + CmpW'(1)) < cnt_x);
  assign up_more    = (ptr_x > pos_x);
  assign dn_more    = ((ptr_x + CmpW'(1)) < cnt_x);

  // request latch
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      act_q <= act_e'(action_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  // state and walk pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EVAL;
      end
      S_EVAL: begin
        unique case (act_q)
          ACT_APPEND: state_d = S_IDLE;
          ACT_INSERT: begin
            if (pos_gt || full || pos_at_end) state_d = S_IDLE;
            else                              state_d = S_SH_UP;
          end
          ACT_DELETE: begin
            if (!pos_ge && del_shift) state_d = S_SH_DN;
            else                      state_d = S_IDLE;
          end
          ACT_READ: begin
            if (pos_ge) state_d = S_IDLE;
            else        state_d = S_RD_WAIT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SH_UP: begin
        if (!up_more) state_d = S_FILL;
      end
      S_FILL:    state_d = S_IDLE;
      S_SH_DN: begin
        if (!dn_more) state_d = S_IDLE;
      end
      S_RD_WAIT: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // RAM access, pointer and completion
  always_comb begin
    mem_o = '0;
    res_o = '0;
    res_o.status = ST_OK;
    ptr_d = ptr_q;
    unique case (state_q)
      S_IDLE: ;
      S_EVAL: begin
        unique case (act_q)
          ACT_APPEND: begin
            res_o.fin = 1'b1;
            if (full) begin
              res_o.status = ST_FULL;
            end else begin
              mem_o.we      = 1'b1;
              mem_o.waddr   = AddrW'(cnt_i);
              mem_o.wdata   = val_q;
              res_o.cnt_inc = 1'b1;
            end
          end
          ACT_INSERT: begin
            if (pos_gt) begin
              res_o.fin    = 1'b1;
              res_o.status = ST_RANGE;
            end else if (full) begin
              res_o.fin    = 1'b1;
              res_o.status = ST_FULL;
            end else if (pos_at_end) begin
              res_o.fin     = 1'b1;
              res_o.cnt_inc = 1'b1;
              mem_o.we      = 1'b1;
              mem_o.waddr   = AddrW'(pos_q);
              mem_o.wdata   = val_q;
            end else begin
              // start the upward shift at the last entry
              mem_o.raddr = AddrW'(cnt_i - CntW'(1));
              ptr_d       = AddrW'(cnt_i - CntW'(1));
            end
          end
          ACT_DELETE: begin
            if (pos_ge) begin
              res_o.fin    = 1'b1;
              res_o.status = ST_RANGE;
            end else if (del_shift) begin
              mem_o.raddr = AddrW'(pos_q) + AddrW'(1);
              ptr_d       = AddrW'(pos_q) + AddrW'(1);
            end else begin
              res_o.fin     = 1'b1;
              res_o.cnt_dec = 1'b1;
            end
          end
          ACT_READ: begin
            if (pos_ge) begin
              res_o.fin    = 1'b1;
              res_o.status = ST_RANGE;
            end else begin
              mem_o.raddr = AddrW'(pos_q);
            end
          end
          default: ;
        endcase
      end
      S_SH_UP: begin
        // move entry ptr up one place, fetch the one below
        mem_o.we    = 1'b1;
        mem_o.waddr = ptr_q + AddrW'(1);
        mem_o.wdata = rdata_i;
        if (up_more) begin
          mem_o.raddr = ptr_q - AddrW'(1);
          ptr_d       = ptr_q - AddrW'(1);
        end
      end
      S_FILL: begin
        mem_o.we      = 1'b1;
        mem_o.waddr   = AddrW'(pos_q);
        mem_o.wdata   = val_q;
        res_o.fin     = 1'b1;
        res_o.cnt_inc = 1'b1;
      end
      S_SH_DN: begin
        // move entry ptr down one place, fetch the one above
        mem_o.we    = 1'b1;
        mem_o.waddr = ptr_q - AddrW'(1);
        mem_o.wdata = rdata_i;
        if (dn_more) begin
          mem_o.raddr = ptr_q + AddrW'(1);
          ptr_d       = ptr_q + AddrW'(1);
        end else begin
          res_o.fin     = 1'b1;
          res_o.cnt_dec = 1'b1;
        end
      end
      S_RD_WAIT: begin
        res_o.fin     = 1'b1;
        res_o.rd_take = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
